/* rtl/hhmm_alarm_clock_top_assert.svh */
// Assertion macros for the HHMM alarm clock RTL.
// Requires clk and rst_n in the scope of each use.
`ifndef HHMM_ALARM_CLOCK_TOP_ASSERT_SVH
`define HHMM_ALARM_CLOCK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HHMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhmm assertion failed");
`define HHMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhmm assertion failed");
`else
`define HHMM_ASSERT_IMP(lbl, ante, cons)
`define HHMM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/hhmm_pkg.sv */
// Shared types, codes and BCD time helpers for the HHMM alarm clock.
// No dependencies.
`default_nettype none
package hhmm_pkg;

  localparam logic [1:0] REQ_MIN  = 2'd0;
  localparam logic [1:0] REQ_BEEP = 2'd1;
  localparam logic [1:0] REQ_POLL = 2'd2;

  localparam logic [1:0] CFG_TPM    = 2'd0;
  localparam logic [1:0] CFG_BEEPON = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;
  localparam logic [1:0] CFG_THRESH = 2'd3;

  localparam logic [3:0]  TPM_RST    = 4'd12;
  localparam logic [10:0] BEEPON_RST = 11'd1000;
  localparam logic [10:0] PERIOD_RST = 11'd2000;
  localparam logic [11:0] THRESH_RST = 12'd4095;

  typedef struct packed {
    logic [1:0] ht;
    logic [3:0] hu;
    logic [2:0] mt;
    logic [3:0] mu;
  } bcd_t;

  localparam bcd_t ALARM_RST = '{ht: 2'd0, hu: 4'd7, mt: 3'd1, mu: 4'd5};

  typedef struct packed {
    logic [3:0]  tpm;
    logic [10:0] beep_on;
    logic [10:0] period;
    logic [11:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        view;
    logic        hour;
    logic        minute;
    logic        clear;
    logic [11:0] light;
  } req_t;

  typedef struct packed {
    logic speaker;
    logic sounding;
    logic view;
    bcd_t shown;
  } stat_t;

  function automatic bcd_t hour_inc(bcd_t v);
    bcd_t r;
    r = v;
    if (v.hu == 4'd9) begin
      r.hu = 4'd0;
      r.ht = v.ht + 2'd1;
    end else begin
      r.hu = v.hu + 4'd1;
    end
    return r;
  endfunction

  function automatic logic is_h23(bcd_t v);
    return (v.ht == 2'd2) && (v.hu == 4'd3);
  endfunction

  function automatic bcd_t next_minute(bcd_t v);
    bcd_t r;
    r = v;
    if (is_h23(v) && v.mt == 3'd5 && v.mu == 4'd9) begin
      r = '0;
    end else if (v.mu == 4'd9) begin
      r.mu = 4'd0;
      if (v.mt == 3'd5) begin
        r.mt = 3'd0;
        r    = hour_inc(r);
      end else begin
        r.mt = v.mt + 3'd1;
      end
    end else begin
      r.mu = v.mu + 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_t clk_hour(bcd_t v);
    bcd_t r;
    r = v;
    if (is_h23(v)) begin
      r.ht = 2'd0;
      r.hu = 4'd0;
    end else begin
      r = hour_inc(v);
    end
    return r;
  endfunction

  function automatic bcd_t alm_hour(bcd_t v);
    return is_h23(v) ? bcd_t'('0) : hour_inc(v);
  endfunction

  // active-low gfedcba
  function automatic logic [6:0] seg7(logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h18;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/hhmm_alarm_clock_top.sv */
// HHMM alarm clock: request/result stream top level with config registers.
// Depends on hhmm_pkg, hhmm_core and hhmm_disp.
//
// Use: each request on the in_ stream is a minute tick, a beep tick or a
// button/light poll (in_tuser). Every request yields exactly one result on
// the out_ stream carrying the state after that request: speaker level,
// alarm flag, view, shown HHMM value, its four digits and 7-segment codes.
// A request accepted on in_ waits in the request register; its result is
// then registered in out_tdata once the output register is free. Throughput:
// one request per cycle while out_tready is high; core state updates with it.
// The request register is refilled while a result waits, so one request is
// held when the receiver stalls; in_tready drops only when both are full.
// Reset (rst_n low, synchronous): clock 0000, alarm 0715, alarm view shown,
// alarm silent, prescaler and beep counter zero, config at its defaults.
// Config writes (cfg_we) take effect at once; issue them only when idle.
`default_nettype none
module hhmm_alarm_clock_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // view, hour, minute, clear, light[11:0]
  input  wire logic [1:0]  in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata, // speaker, sounding, showing_alarm,
                                      // shown_value[11:0], d_thousands[1:0],
                                      // d_hundreds[3:0], d_tens[2:0],
                                      // d_ones[3:0], segments_n[27:0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [11:0] cfg_wdata
);

  hhmm_pkg::cfg_t  cfg_r;
  hhmm_pkg::req_t  rq_r;
  hhmm_pkg::stat_t stat;
  logic            in_valid_r;
  logic            out_valid_r;
  logic [55:0]     out_data_r, out_data_nxt;
  logic            advance;
  logic [11:0]     value;
  logic [27:0]     segs_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tpm     <= hhmm_pkg::TPM_RST;
      cfg_r.beep_on <= hhmm_pkg::BEEPON_RST;
      cfg_r.period  <= hhmm_pkg::PERIOD_RST;
      cfg_r.thresh  <= hhmm_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hhmm_pkg::CFG_TPM:    cfg_r.tpm     <= cfg_wdata[3:0];
        hhmm_pkg::CFG_BEEPON: cfg_r.beep_on <= cfg_wdata[10:0];
        hhmm_pkg::CFG_PERIOD: cfg_r.period  <= cfg_wdata[10:0];
        hhmm_pkg::CFG_THRESH: cfg_r.thresh  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rq_r <= '{kind: in_tuser, view: in_tdata[0], hour: in_tdata[1],
                minute: in_tdata[2], clear: in_tdata[3], light: in_tdata[15:4]};
    end
  end

  hhmm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (advance),
    .rq    (rq_r),
    .cfg   (cfg_r),
    .stat  (stat)
  );

  hhmm_disp u_disp (
    .t      (stat.shown),
    .value  (value),
    .segs_n (segs_n)
  );

  assign out_data_nxt = {segs_n, stat.shown.mu, stat.shown.mt, stat.shown.hu,
                         stat.shown.ht, value, stat.view, stat.sounding, stat.speaker};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* rtl/hhmm_core.sv */
// Clock, alarm, prescaler and beeper state with per-request update logic.
// Depends on hhmm_pkg and hhmm_alarm_clock_top_assert.svh.
`default_nettype none
`include "hhmm_alarm_clock_top_assert.svh"
module hhmm_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          upd,
  input  wire hhmm_pkg::req_t rq,
  input  wire hhmm_pkg::cfg_t cfg,
  output hhmm_pkg::stat_t    stat
);

  hhmm_pkg::bcd_t clk_r, clk_nxt, alm_r, alm_nxt;
  logic           view_r, view_nxt;
  logic           snd_r, snd_nxt;
  logic           spk_r, spk_nxt;
  logic [3:0]     pre_r, pre_nxt;
  logic [10:0]    beep_r, beep_nxt;

  always_comb begin
    hhmm_pkg::bcd_t tgt;
    logic [11:0]    bc1;
    clk_nxt  = clk_r;
    alm_nxt  = alm_r;
    view_nxt = view_r;
    snd_nxt  = snd_r;
    spk_nxt  = spk_r;
    pre_nxt  = pre_r;
    beep_nxt = beep_r;
    tgt      = clk_r;
    bc1      = {1'b0, beep_r} + 12'd1;
    unique case (rq.kind)
      hhmm_pkg::REQ_MIN: begin
        if (pre_r >= cfg.tpm) begin
          clk_nxt = hhmm_pkg::next_minute(clk_r);
          pre_nxt = 4'd1;
        end else begin
          pre_nxt = pre_r + 4'd1;
        end
      end
      hhmm_pkg::REQ_BEEP: begin
        if (snd_r) begin
          if (beep_r < cfg.beep_on) spk_nxt = ~spk_r;
          beep_nxt = (bc1 >= {1'b0, cfg.period}) ? 11'd0 : bc1[10:0];
        end
      end
      hhmm_pkg::REQ_POLL: begin
        view_nxt = view_r ^ rq.view;
        tgt      = view_nxt ? alm_r : clk_r;
        if (rq.hour) tgt = view_nxt ? hhmm_pkg::alm_hour(tgt) : hhmm_pkg::clk_hour(tgt);
        if (rq.minute) tgt = hhmm_pkg::next_minute(tgt);
        if (rq.clear) tgt = '0;
        if (view_nxt) alm_nxt = tgt;
        else          clk_nxt = tgt;
        if (clk_nxt == alm_nxt) snd_nxt = 1'b1;
        if (rq.light < cfg.thresh) snd_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_r  <= '0;
      alm_r  <= hhmm_pkg::ALARM_RST;
      view_r <= 1'b1;
      snd_r  <= 1'b0;
      spk_r  <= 1'b0;
      pre_r  <= 4'd0;
      beep_r <= 11'd0;
    end else if (upd) begin
      clk_r  <= clk_nxt;
      alm_r  <= alm_nxt;
      view_r <= view_nxt;
      snd_r  <= snd_nxt;
      spk_r  <= spk_nxt;
      pre_r  <= pre_nxt;
      beep_r <= beep_nxt;
    end
  end

  assign stat.speaker  = spk_nxt;
  assign stat.sounding = snd_nxt;
  assign stat.view     = view_nxt;
  assign stat.shown    = view_nxt ? alm_nxt : clk_nxt;

  `HHMM_ASSERT_NXT(a_snd_rise, !snd_r && !(upd && rq.kind == hhmm_pkg::REQ_POLL), !snd_r)
  `HHMM_ASSERT_NXT(a_spk_hold, !(upd && rq.kind == hhmm_pkg::REQ_BEEP && snd_r), spk_r == $past(spk_r))
  `HHMM_ASSERT_IMP(a_clk_bcd, 1'b1, clk_r.mt <= 3'd5 && clk_r.mu <= 4'd9 && clk_r.hu <= 4'd9)
  `HHMM_ASSERT_IMP(a_alm_bcd, 1'b1, alm_r.mt <= 3'd5 && alm_r.mu <= 4'd9 && alm_r.hu <= 4'd9)

endmodule
`default_nettype wire

/* rtl/hhmm_disp.sv */
// Display encoder: BCD time to binary HHMM value, digits and segment codes.
// Depends on hhmm_pkg.
`default_nettype none
module hhmm_disp (
  input  wire hhmm_pkg::bcd_t t,
  output logic [11:0]       value,
  output logic [27:0]       segs_n
);

  assign value = 12'(t.ht) * 12'd1000 + 12'(t.hu) * 12'd100
               + 12'(t.mt) * 12'd10 + 12'(t.mu);

  assign segs_n = {hhmm_pkg::seg7({2'b00, t.ht}), hhmm_pkg::seg7(t.hu),
                   hhmm_pkg::seg7({1'b0, t.mt}), hhmm_pkg::seg7(t.mu)};

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for hhmm_alarm_clock_top: drives minute ticks, beep ticks and polls
// through the request stream and checks every result against a local model.
// Depends on hhmm_pkg and the block's RTL.
module tb_top;

  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [27:0] segments_n;
    logic [3:0]  digit_ones;
    logic [2:0]  digit_tens;
    logic [3:0]  digit_hundreds;
    logic [1:0]  digit_thousands;
    logic [11:0] shown_value;
    logic        showing_alarm;
    logic        alarm_sounding;
    logic        speaker_level;
  } display_t;

  class alarm_clock_scoreboard;
    logic [3:0]  tpm;
    logic [10:0] beep_on;
    logic [10:0] period;
    logic [11:0] thresh;
    logic [11:0] clock_hhmm;
    logic [11:0] alarm_hhmm;
    logic        view;
    logic        sounding;
    logic        speaker;
    logic [3:0]  prescale;
    logic [10:0] beep_cnt;
    logic [6:0]  glyph [16];
    display_t    display_q[$];
    int          mismatches;

    function new();
      tpm        = 4'd12;
      beep_on    = 11'd1000;
      period     = 11'd2000;
      thresh     = 12'd4095;
      clock_hhmm = 12'd0;
      alarm_hhmm = 12'd715;
      view       = 1'b1;
      sounding   = 1'b0;
      speaker    = 1'b0;
      prescale   = 4'd0;
      beep_cnt   = 11'd0;
      mismatches = 0;
      glyph = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78,
                7'h00, 7'h18, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F};
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] val);
      case (idx)
        hhmm_pkg::CFG_TPM:    tpm = val[3:0];
        hhmm_pkg::CFG_BEEPON: beep_on = val[10:0];
        hhmm_pkg::CFG_PERIOD: period = val[10:0];
        hhmm_pkg::CFG_THRESH: thresh = val[11:0];
        default: ;
      endcase
    endfunction

    function logic [11:0] bump_minute(logic [11:0] v);
      if (v == 12'd2359) return 12'd0;
      if (v % 12'd100 == 12'd59) return v + 12'd41;
      return v + 12'd1;
    endfunction

    function void advance(logic [1:0] kind, logic [15:0] data);
      logic [11:0] nxt;
      display_t    d;
      logic [11:0] s;
      case (kind)
        hhmm_pkg::REQ_MIN: begin
          if (prescale >= tpm) begin
            clock_hhmm = bump_minute(clock_hhmm);
            prescale   = 4'd0;
          end
          prescale = prescale + 4'd1;
        end
        hhmm_pkg::REQ_BEEP: begin
          if (sounding) begin
            if (beep_cnt < beep_on) speaker = ~speaker;
            nxt = {1'b0, beep_cnt} + 12'd1;
            if (nxt >= {1'b0, period}) nxt = 12'd0;
            beep_cnt = nxt[10:0];
          end
        end
        hhmm_pkg::REQ_POLL: begin
          if (data[0]) view = ~view;
          if (data[1]) begin
            if (!view) begin
              if (clock_hhmm / 12'd100 == 12'd23) clock_hhmm = clock_hhmm - 12'd2300;
              else clock_hhmm = clock_hhmm + 12'd100;
            end else begin
              if (alarm_hhmm / 12'd100 == 12'd23) alarm_hhmm = 12'd0;
              else alarm_hhmm = alarm_hhmm + 12'd100;
            end
          end
          if (data[2]) begin
            if (!view) clock_hhmm = bump_minute(clock_hhmm);
            else alarm_hhmm = bump_minute(alarm_hhmm);
          end
          if (data[3]) begin
            if (!view) clock_hhmm = 12'd0;
            else alarm_hhmm = 12'd0;
          end
          if (clock_hhmm == alarm_hhmm) sounding = 1'b1;
          if (data[15:4] < thresh) sounding = 1'b0;
        end
        default: ;
      endcase
      s = view ? alarm_hhmm : clock_hhmm;
      d.speaker_level   = speaker;
      d.alarm_sounding  = sounding;
      d.showing_alarm   = view;
      d.shown_value     = s;
      d.digit_thousands = 2'(s / 12'd1000);
      d.digit_hundreds  = 4'((s / 12'd100) % 12'd10);
      d.digit_tens      = 3'((s / 12'd10) % 12'd10);
      d.digit_ones      = 4'(s % 12'd10);
      d.segments_n = {glyph[4'(s / 12'd1000)], glyph[4'((s / 12'd100) % 12'd10)],
                      glyph[4'((s / 12'd10) % 12'd10)], glyph[4'(s % 12'd10)]};
      display_q.push_back(d);
    endfunction

    function void report(string what, logic [55:0] want, logic [55:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void cmp(string name, logic [27:0] want, logic [27:0] got);
      if (got !== want) report(name, 56'(want), 56'(got));
    endfunction

    function void check_display(logic [55:0] raw);
      display_t got, want;
      got = raw;
      if (display_q.size() == 0) begin
        report("unexpected result", 56'd0, raw);
        return;
      end
      want = display_q.pop_front();
      cmp("speaker_level", 28'(want.speaker_level), 28'(got.speaker_level));
      cmp("alarm_sounding", 28'(want.alarm_sounding), 28'(got.alarm_sounding));
      cmp("showing_alarm", 28'(want.showing_alarm), 28'(got.showing_alarm));
      cmp("shown_value", 28'(want.shown_value), 28'(got.shown_value));
      cmp("digit_thousands", 28'(want.digit_thousands), 28'(got.digit_thousands));
      cmp("digit_hundreds", 28'(want.digit_hundreds), 28'(got.digit_hundreds));
      cmp("digit_tens", 28'(want.digit_tens), 28'(got.digit_tens));
      cmp("digit_ones", 28'(want.digit_ones), 28'(got.digit_ones));
      cmp("segments_n", want.segments_n, got.segments_n);
    endfunction

    function int pending();
      return display_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = 2'd0;
  logic [11:0] cfg_wdata = 12'd0;

  alarm_clock_scoreboard sb;
  bit          quiet = 1'b0;
  bit          view_guess = 1'b1;
  int unsigned cur_thr = 4095;
  int          sent = 0;
  int          stall_cycles = 0;

  hhmm_alarm_clock_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_display(out_tdata);
      if (in_tvalid && in_tready) sb.advance(in_tuser, in_tdata);
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && (quiet || $urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] kind, input bit view, input bit hour,
                      input bit minute, input bit clr, input logic [11:0] light);
    while (!quiet && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {light, clr, minute, hour, view};
    if (kind == hhmm_pkg::REQ_POLL && view) view_guess = !view_guess;
    sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [11:0] bright();
    return 12'($urandom_range(4095, cur_thr));
  endfunction

  function automatic logic [11:0] dim();
    return (cur_thr == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(cur_thr - 1, 0));
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_regs(input int unsigned tpm, input int unsigned beep_on,
                           input int unsigned period, input int unsigned thr);
    in_tvalid <= 1'b0;
    wait_idle();
    write_reg(hhmm_pkg::CFG_TPM, 12'(tpm));
    write_reg(hhmm_pkg::CFG_BEEPON, 12'(beep_on));
    write_reg(hhmm_pkg::CFG_PERIOD, 12'(period));
    write_reg(hhmm_pkg::CFG_THRESH, 12'(thr));
    cfg_we  <= 1'b0;
    cur_thr = thr;
  endtask

  // clear the shown value in the wanted view, then press up to hh:mm
  task automatic set_shown(input bit want_alarm, input int hh, input int mm);
    int n;
    n = (hh > mm) ? hh : mm;
    send(hhmm_pkg::REQ_POLL, view_guess != want_alarm, 1'b0, 1'b0, 1'b1, bright());
    for (int i = 0; i < n; i++)
      send(hhmm_pkg::REQ_POLL, 1'b0, i < hh, i < mm, 1'b0,
           ($urandom_range(9) == 0) ? dim() : bright());
  endtask

  task automatic alarm_scenario();
    int hh, mm;
    hh = ($urandom_range(3) == 0) ? $urandom_range(24, 23) : $urandom_range(23);
    mm = ($urandom_range(3) == 0) ? $urandom_range(60, 59) : $urandom_range(60);
    set_shown(1'b1, hh, mm);
    if ($urandom_range(9) < 7) set_shown(1'b0, hh, mm);
    else set_shown(1'b0, $urandom_range(24), $urandom_range(60));
    repeat ($urandom_range(40, 4)) begin
      case ($urandom_range(19))
        0, 1, 2: send(hhmm_pkg::REQ_MIN, 1'b0, 1'b0, 1'b0, 1'b0,
                      12'($urandom_range(4095)));
        3, 4, 5: send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b0, 1'b0, bright());
        default: send(hhmm_pkg::REQ_BEEP, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      12'($urandom_range(4095)));
      endcase
    end
    if ($urandom_range(1)) begin
      send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b0, 1'b0, dim());
      repeat ($urandom_range(5)) send(hhmm_pkg::REQ_BEEP, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
    end
  endtask

  task automatic noise_burst();
    logic [1:0] kind;
    repeat ($urandom_range(30, 5)) begin
      kind = ($urandom_range(19) == 0) ? REQ_UNUSED : 2'($urandom_range(2));
      send(kind, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
           $urandom_range(3) == 0, 12'($urandom_range(4095)));
    end
  endtask

  task automatic run_phase(input int n_items);
    int start;
    start = sent;
    while (sent - start < n_items) begin
      if ($urandom_range(9) < 6) alarm_scenario();
      else noise_burst();
    end
  endtask

  task automatic directed();
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b0, 1'b0, 12'd4095);
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
    send(REQ_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, 12'hFFF);
    send(hhmm_pkg::REQ_BEEP, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
    send(hhmm_pkg::REQ_MIN, 1'b1, 1'b1, 1'b1, 1'b1, 12'hFFF);
    send(hhmm_pkg::REQ_POLL, 1'b1, 1'b0, 1'b0, 1'b0, 12'd4095);
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b1, 1'b0, 12'd4095);
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 12'd4095);
    send(hhmm_pkg::REQ_POLL, 1'b1, 1'b1, 1'b1, 1'b1, 12'd4095);
    send(hhmm_pkg::REQ_POLL, 1'b1, 1'b0, 1'b0, 1'b1, 12'd4095);
    repeat (6) send(hhmm_pkg::REQ_BEEP, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b0, 1'b0, 12'd4094);
    send(hhmm_pkg::REQ_BEEP, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b0, 1'b1, 12'd4095);
    send(hhmm_pkg::REQ_BEEP, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b1, 1'b0, 1'b0, 12'd4095);
    send(hhmm_pkg::REQ_MIN, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
    send(hhmm_pkg::REQ_POLL, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    directed();
    load_regs(1, 3, 5, 2048);
    run_phase(280);
    load_regs(0, 0, 0, 0);
    run_phase(280);
    quiet = 1'b1;
    load_regs(15, 2047, 2047, 4095);
    run_phase(280);
    quiet = 1'b0;
    load_regs(2, 7, 4, 100);
    run_phase(280);
    repeat (2) begin
      load_regs($urandom_range(15), $urandom_range(24), $urandom_range(20),
                $urandom_range(4095));
      run_phase(280);
    end
    in_tvalid <= 1'b0;
    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
